// ===== src/mhpq_pkg.sv =====
// Shared types, sizes and helpers for the min-heap priority queue.
// Used by every module of the block but mhpq_ram; depends on nothing else.
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 7;
  // Nodes are numbered from 1, so node DEPTH needs this many bits; it is also
  // the number of heap levels, one cell per level.
  localparam int unsigned NODE_W  = $clog2(DEPTH + 1);
  localparam int unsigned NLEV    = NODE_W;
  localparam int unsigned LVL_W   = $clog2(NLEV);
  localparam int unsigned ENTRY_W = KEY_W + ADDR_W;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [0:0] {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    MODE_INSERT = 1'b0,
    MODE_SIFT   = 1'b1
  } mode_e;

  typedef struct packed {
    op_e               op;
    logic [KEY_W-1:0]  entry_size;
    logic [ADDR_W-1:0] entry_address;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [KEY_W-1:0]  out_size;
    logic [ADDR_W-1:0] out_address;
    count_t            count;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  // Two sibling nodes of one level: even node in lo, odd node in hi.
  typedef struct packed {
    entry_t hi;
    entry_t lo;
  } pair_t;

  // Work token handed from one level cell to the next.
  // Insert: node is the target node, sh the distance from this level to it.
  // Sift: node is the parent whose children this level holds.
  typedef struct packed {
    logic   valid;
    mode_e  mode;
    entry_t ent;
    node_t  node;
    lvl_t   sh;
    logic   placed;
  } tok_t;

  typedef struct packed {
    logic   we;
    node_t  pair;
    logic   par;
    entry_t ent;
  } wr_t;

  typedef struct packed {
    logic  valid;
    node_t node;
  } peek_t;

  typedef struct packed {
    logic   re;
    node_t  raddr;
    logic   we_lo;
    logic   we_hi;
    node_t  waddr;
    entry_t wdata;
  } ramreq_t;

  // Level of a node: index of its leading one.
  function automatic lvl_t msb_index(node_t n);
    lvl_t idx;
    idx = '0;
    for (int i = 0; i < NODE_W; i++) begin
      if (n[i]) begin
        idx = lvl_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== src/min_heap_priority_queue.sv =====
// Top level of the min-heap priority queue: request control and a chain of level cells.
// Depends on mhpq_pkg, mhpq_cell and mhpq_ram.
//
//   channel   ports                   transfer
//   --------  ----------------------  ----------------------------------------
//   request   start, busy, req_i      taken at a rising edge with start & !busy
//   result    res_strobe_o, res_o     valid for the single strobed cycle
//
// Insert: result the cycle after the request; busy while the token walks the level
// cells down to the level of the new last node, each cell reading, then deciding.
// Extract: result follows the S_PEEK and S_LOAD states (root and last node fetched);
// busy then stays up while the sift-down walks the levels.
// Full or empty cases answer the next cycle.
// Reset clears the entry count and the control registers; the stores need no clearing pass.
// Results cannot be held off: each is shown for exactly one strobed cycle.
`timescale 1ns / 1ps

module min_heap_priority_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  mhpq_pkg::req_t req_i,
  output logic           busy,
  output mhpq_pkg::res_t res_o,
  output logic           res_strobe_o
);
  import mhpq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PEEK,
    S_LOAD,
    S_RUN
  } state_e;

  state_e  state_q, state_d;
  node_t   cnt_q, cnt_d, last_q, last_d, cnt_inc;
  lvl_t    dl_q, dl_d;
  tok_t    ins_q, ins_d, sift_q, sift_d;
  res_t    res_q, res_d;
  logic    strobe_q, strobe_d;
  logic    accept;
  entry_t  root_ent, last_ent;

  tok_t             tok_in  [NLEV];
  tok_t             tok_out [NLEV];
  wr_t              up_in   [NLEV];
  wr_t              up_out  [NLEV];
  peek_t            peek    [NLEV];
  ramreq_t          ram     [NLEV];
  pair_t            rd      [NLEV];
  logic [NLEV-1:0]  done;

  assign accept   = start && (state_q == S_IDLE);
  assign cnt_inc  = cnt_q + node_t'(1);
  assign root_ent = rd[0].hi;
  assign last_ent = last_q[0] ? rd[dl_q].hi : rd[dl_q].lo;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    dl_d     = dl_q;
    ins_d    = '0;
    sift_d   = '0;
    res_d    = res_q;
    strobe_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.out_size    = '0;
          res_d.out_address = '0;
          if (req_i.op == OP_INSERT) begin
            strobe_d = 1'b1;
            if (cnt_q == node_t'(DEPTH)) begin
              res_d.status = ST_FULL;
              res_d.count  = count_t'(cnt_q);
            end else begin
              res_d.status   = ST_OK;
              res_d.count    = count_t'(cnt_inc);
              cnt_d          = cnt_inc;
              ins_d.valid    = 1'b1;
              ins_d.mode     = MODE_INSERT;
              ins_d.ent.key  = req_i.entry_size;
              ins_d.ent.addr = req_i.entry_address;
              ins_d.node     = cnt_inc;
              ins_d.sh       = msb_index(cnt_inc);
              ins_d.placed   = 1'b0;
              state_d        = S_RUN;
            end
          end else begin
            if (cnt_q == '0) begin
              strobe_d     = 1'b1;
              res_d.status = ST_EMPTY;
              res_d.count  = '0;
            end else begin
              last_d  = cnt_q;
              dl_d    = msb_index(cnt_q);
              cnt_d   = cnt_q - node_t'(1);
              state_d = S_PEEK;
            end
          end
        end
      end
      S_PEEK: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        strobe_d          = 1'b1;
        res_d.status      = ST_OK;
        res_d.out_size    = root_ent.key;
        res_d.out_address = root_ent.addr;
        res_d.count       = count_t'(cnt_q);
        if (cnt_q == '0) begin
          state_d = S_IDLE;
        end else begin
          // move the last entry to the root and sift it down from there
          sift_d.valid  = 1'b1;
          sift_d.mode   = MODE_SIFT;
          sift_d.ent    = last_ent;
          sift_d.node   = node_t'(1);
          sift_d.sh     = '0;
          sift_d.placed = 1'b0;
          state_d       = S_RUN;
        end
      end
      S_RUN: begin
        if (|done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      last_q   <= '0;
      dl_q     <= '0;
      ins_q    <= '0;
      sift_q   <= '0;
      res_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
      dl_q     <= dl_d;
      ins_q    <= ins_d;
      sift_q   <= sift_d;
      res_q    <= res_d;
      strobe_q <= strobe_d;
    end
  end

  for (genvar l = 0; l < NLEV; l++) begin : g_lvl
    localparam int unsigned AW = (l > 1) ? l - 1 : 1;

    if (l == 0) begin : g_in_root
      assign tok_in[l] = ins_q;
    end else if (l == 1) begin : g_in_first
      assign tok_in[l] = tok_out[0].valid ? tok_out[0] : sift_q;
    end else begin : g_in_chain
      assign tok_in[l] = tok_out[l-1];
    end

    if (l == NLEV - 1) begin : g_up_last
      assign up_in[l] = '0;
    end else begin : g_up_chain
      assign up_in[l] = up_out[l+1];
    end

    assign peek[l].valid = (state_q == S_PEEK) && ((l == 0) || (dl_q == lvl_t'(l)));
    assign peek[l].node  = (dl_q == lvl_t'(l)) ? last_q : node_t'(1);

    mhpq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_in[l]),
      .peek_i (peek[l]),
      .up_i   (up_in[l]),
      .lim_i  (cnt_q),
      .rd_i   (rd[l]),
      .tok_o  (tok_out[l]),
      .up_o   (up_out[l]),
      .ram_o  (ram[l]),
      .done_o (done[l])
    );

    mhpq_ram #(
      .Width (ENTRY_W),
      .Depth (2 ** AW)
    ) u_ram_lo (
      .clk_i   (clk_i),
      .we_i    (ram[l].we_lo),
      .waddr_i (ram[l].waddr[AW-1:0]),
      .wdata_i (ram[l].wdata),
      .re_i    (ram[l].re),
      .raddr_i (ram[l].raddr[AW-1:0]),
      .rdata_o (rd[l].lo)
    );

    mhpq_ram #(
      .Width (ENTRY_W),
      .Depth (2 ** AW)
    ) u_ram_hi (
      .clk_i   (clk_i),
      .we_i    (ram[l].we_hi),
      .waddr_i (ram[l].waddr[AW-1:0]),
      .wdata_i (ram[l].wdata),
      .re_i    (ram[l].re),
      .raddr_i (ram[l].raddr[AW-1:0]),
      .rdata_o (rd[l].hi)
    );
  end

  assign busy         = (state_q != S_IDLE);
  assign res_o        = res_q;
  assign res_strobe_o = strobe_q;

endmodule

// ===== src/mhpq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; sized by its parameters.
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mhpq_cell.sv =====
// One heap level: reads its sibling pair, compares, writes and hands the token on.
// Depends on mhpq_pkg; drives the two RAM banks of its level.
`timescale 1ns / 1ps

module mhpq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mhpq_pkg::tok_t    tok_i,
  input  mhpq_pkg::peek_t   peek_i,
  input  mhpq_pkg::wr_t     up_i,
  input  mhpq_pkg::node_t   lim_i,
  input  mhpq_pkg::pair_t   rd_i,
  output mhpq_pkg::tok_t    tok_o,
  output mhpq_pkg::wr_t     up_o,
  output mhpq_pkg::ramreq_t ram_o,
  output logic              done_o
);
  import mhpq_pkg::*;

  tok_t              tok_q;
  tok_t              out_q, out_d;
  node_t             node_a, node_b, child_n;
  entry_t            cur, child;
  logic [NODE_W:0]   lft, rgt, grand, lim_x;
  logic              take_l, take_r, place;
  logic [KEY_W-1:0]  best_key;
  wr_t               own, wr;

  always_comb begin
    // first step: fetch the pair this token needs
    node_a = tok_i.node >> tok_i.sh;
    ram_o  = '0;
    ram_o.re = tok_i.valid || peek_i.valid;
    if (tok_i.valid) begin
      ram_o.raddr = (tok_i.mode == MODE_INSERT) ? (node_a >> 1) : tok_i.node;
    end else begin
      ram_o.raddr = peek_i.node >> 1;
    end

    // second step: decide with the pair in hand
    node_b   = tok_q.node >> tok_q.sh;
    cur      = node_b[0] ? rd_i.hi : rd_i.lo;
    lft      = {tok_q.node, 1'b0};
    rgt      = {tok_q.node, 1'b1};
    lim_x    = {1'b0, lim_i};
    take_l   = (lft <= lim_x) && (rd_i.lo.key < tok_q.ent.key);
    best_key = take_l ? rd_i.lo.key : tok_q.ent.key;
    take_r   = (rgt <= lim_x) && (rd_i.hi.key < best_key);
    child    = take_r ? rd_i.hi : rd_i.lo;
    child_n  = take_r ? rgt[NODE_W-1:0] : lft[NODE_W-1:0];
    grand    = {child_n, 1'b0};
    place    = tok_q.placed || (tok_q.ent.key < cur.key);

    own    = '0;
    up_o   = '0;
    out_d  = '0;
    done_o = 1'b0;
    if (tok_q.valid) begin
      case (tok_q.mode)
        MODE_INSERT: begin
          own.pair = node_b >> 1;
          own.par  = node_b[0];
          own.ent  = tok_q.ent;
          if (tok_q.sh == '0) begin
            own.we = 1'b1;
            done_o = 1'b1;
          end else begin
            // once placed, push every node below down the path
            own.we       = place;
            out_d        = tok_q;
            out_d.ent    = place ? cur : tok_q.ent;
            out_d.placed = place;
            out_d.sh     = tok_q.sh - lvl_t'(1);
          end
        end
        MODE_SIFT: begin
          up_o.we   = 1'b1;
          up_o.pair = tok_q.node >> 1;
          up_o.par  = tok_q.node[0];
          if (take_l || take_r) begin
            up_o.ent = child;
            if (grand <= lim_x) begin
              out_d      = tok_q;
              out_d.node = child_n;
            end else begin
              // child is a leaf: drop the moving entry there
              own.we   = 1'b1;
              own.pair = child_n >> 1;
              own.par  = child_n[0];
              own.ent  = tok_q.ent;
              done_o   = 1'b1;
            end
          end else begin
            up_o.ent = tok_q.ent;
            done_o   = 1'b1;
          end
        end
        default: begin
          done_o = 1'b0;
        end
      endcase
    end

    wr          = own.we ? own : up_i;
    ram_o.we_lo = wr.we && !wr.par;
    ram_o.we_hi = wr.we && wr.par;
    ram_o.waddr = wr.pair;
    ram_o.wdata = wr.ent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      out_q <= '0;
    end else begin
      tok_q <= tok_i;
      out_q <= out_d;
    end
  end

  assign tok_o = out_q;

endmodule

// ===== src/mhpq_checker.sv =====
// Port-level checks for the min-heap priority queue, bound to the top level.
// Depends on mhpq_pkg; sees only the top-level ports.
`timescale 1ns / 1ps

module mhpq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input mhpq_pkg::req_t req_i,
  input logic           busy,
  input mhpq_pkg::res_t res_o,
  input logic           res_strobe_o
);
  import mhpq_pkg::*;

  // an accepted request either answers at once or holds the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || res_strobe_o)
    else $error("accepted request neither answered nor held busy");

  // busy only rises in response to a request
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.status == ST_EMPTY |->
      res_o.out_size == '0 && res_o.out_address == '0 && res_o.count == '0)
    else $error("empty extract returned data or a nonzero count");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.status == ST_FULL |->
      res_o.out_size == '0 && res_o.out_address == '0 &&
      res_o.count == count_t'(DEPTH))
    else $error("full insert reported wrong count or data");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

// ===== verif/mhpq_result_checker.sv =====
// Result checker for the min-heap priority queue: predicts every result from the
// accepted requests with its own heap and compares the strobed results in order.
// Depends on mhpq_pkg only.
`timescale 1ns / 1ps

module mhpq_result_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  mhpq_pkg::req_t req_i,
  input  mhpq_pkg::res_t res_i,
  input  logic           res_strobe_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o,
  output int unsigned    checked_o,
  output int unsigned    full_seen_o,
  output int unsigned    empty_seen_o
);
  import mhpq_pkg::*;

  logic [KEY_W-1:0]  heap_key  [DEPTH];
  logic [ADDR_W-1:0] heap_addr [DEPTH];
  int unsigned       held;
  res_t              expected_results[$];
  int unsigned       failures;
  int unsigned       checked;
  int unsigned       full_seen;
  int unsigned       empty_seen;

  function automatic void swap_nodes(int unsigned a, int unsigned b);
    logic [KEY_W-1:0]  k;
    logic [ADDR_W-1:0] d;
    k            = heap_key[a];
    d            = heap_addr[a];
    heap_key[a]  = heap_key[b];
    heap_addr[a] = heap_addr[b];
    heap_key[b]  = k;
    heap_addr[b] = d;
  endfunction

  // Apply one request to the predicted heap and return the result it causes.
  function automatic res_t heap_apply(req_t rq);
    res_t        r;
    int unsigned pos;
    int unsigned parent;
    int unsigned left;
    int unsigned best;
    r        = '0;
    r.status = ST_OK;
    if (rq.op == OP_INSERT) begin
      if (held >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos            = held;
        heap_key[pos]  = rq.entry_size;
        heap_addr[pos] = rq.entry_address;
        held++;
        // Sift up only while strictly smaller than the parent.
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_key[pos] >= heap_key[parent]) break;
          swap_nodes(pos, parent);
          pos = parent;
        end
      end
    end else if (held == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.out_size    = heap_key[0];
      r.out_address = heap_addr[0];
      held--;
      heap_key[0]  = heap_key[held];
      heap_addr[0] = heap_addr[held];
      pos          = 0;
      // Left child wins ties; swap only when the chosen child is strictly smaller.
      while (2 * pos + 1 < held) begin
        left = 2 * pos + 1;
        best = pos;
        if (heap_key[left] < heap_key[best]) best = left;
        if (left + 1 < held && heap_key[left + 1] < heap_key[best]) best = left + 1;
        if (best == pos) break;
        swap_nodes(pos, best);
        pos = best;
      end
    end
    r.count = count_t'(held);
    return r;
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= 10) begin
        $display("[%0t] result %0d: %s expected %h, got %h", $realtime, checked, field,
                 want, got);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      held       = 0;
      failures   = 0;
      checked    = 0;
      full_seen  = 0;
      empty_seen = 0;
      expected_results.delete();
    end else begin
      if (res_strobe_i) begin
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("[%0t] result with no request outstanding: %p", $realtime, res_i);
          end
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(want.status), 32'(res_i.status));
          compare_field("out_size", want.out_size, res_i.out_size);
          compare_field("out_address", want.out_address, res_i.out_address);
          compare_field("count", 32'(want.count), 32'(res_i.count));
        end
        checked++;
        if (res_i.status == ST_FULL) full_seen++;
        if (res_i.status == ST_EMPTY) empty_seen++;
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(heap_apply(req_i));
      end
    end
    // Publish with nonblocking updates so readers at this edge see stable values.
    fail_count_o <= failures;
    pending_o    <= expected_results.size();
    checked_o    <= checked;
    full_seen_o  <= full_seen;
    empty_seen_o <= empty_seen;
  end

endmodule

// ===== verif/min_heap_priority_queue_test.sv =====
// Testbench top for the min-heap priority queue: clock, reset, request stimulus
// and the final verdict. Depends on mhpq_pkg, mhpq_result_checker and the block.
`timescale 1ns / 1ps

module min_heap_priority_queue_test;
  import mhpq_pkg::*;

  localparam int unsigned DRAIN_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 2 * NLEV + 8;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        res_strobe_o;
  req_t        req_i;
  res_t        res_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned full_seen;
  int unsigned empty_seen;
  int unsigned sent;
  bit          idle_allowed;

  min_heap_priority_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .res_o       (res_o),
    .res_strobe_o(res_strobe_o)
  );

  mhpq_result_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .res_i       (res_o),
    .res_strobe_i(res_strobe_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .full_seen_o (full_seen),
    .empty_seen_o(empty_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Keys lean toward a few small values so that ties occur often.
  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4, 5: return KEY_W'($urandom_range(0, 7));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  task automatic issue_request(op_e op, logic [KEY_W-1:0] key, logic [ADDR_W-1:0] addr);
    req_t        rq;
    int unsigned gap;
    rq.op            = op;
    rq.entry_size    = key;
    rq.entry_address = addr;
    if (idle_allowed && $urandom_range(0, 99) < 31) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic run_mix(int unsigned n, int unsigned insert_pct);
    op_e op;
    repeat (n) begin
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
      issue_request(op, rand_key(), ADDR_W'($urandom));
    end
  endtask

  initial begin
    int unsigned waited;
    start        = 1'b0;
    req_i        = '0;
    rst_ni       = 1'b0;
    idle_allowed = 1'b1;
    sent         = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extract from empty, key and address extremes, equal keys.
    issue_request(OP_EXTRACT, '1, '1);
    issue_request(OP_INSERT, '1, '1);
    issue_request(OP_INSERT, '0, '0);
    issue_request(OP_INSERT, 32'd7, 32'h0000_0001);
    issue_request(OP_INSERT, 32'd7, 32'h0000_0002);
    issue_request(OP_INSERT, 32'd7, 32'h0000_0003);
    issue_request(OP_INSERT, 32'd7, 32'h0000_0004);
    issue_request(OP_INSERT, 32'd3, 32'h8000_0000);
    issue_request(OP_INSERT, 32'h8000_0000, 32'hAAAA_5555);
    issue_request(OP_INSERT, 32'h7FFF_FFFF, 32'h5555_AAAA);
    repeat (10) issue_request(OP_EXTRACT, '0, '0);
    issue_request(OP_EXTRACT, '0, '0);

    // Random: fill past full, drain past empty, then mixed traffic.
    run_mix(120, 90);
    run_mix(120, 10);
    idle_allowed = 1'b0;
    run_mix(130, 55);
    idle_allowed = 1'b1;
    run_mix(130, 50);
    start <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending != 0) begin
      $display("%0d expected results never arrived", pending);
    end

    $display("Sent %0d requests; %0d results compared against the predicted heap.",
             sent, checked);
    $display("Results on a full heap: %0d, on an empty heap: %0d.", full_seen, empty_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
